/* src/two_level_page_table_manager_assert.svh */
// Assertion macros for the page table manager.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH

// Property that must hold on every edge outside reset.
`define TLPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define TLPT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* src/tlpt_pkg.sv */
package tlpt_pkg;

    localparam int PoolSlotsDef = 64;
    localparam int EntriesDef   = 1024;

    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_MAP    = 2'd2;
    localparam logic [1:0] REQ_UNMAP  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;

    localparam int BIT_P  = 0;
    localparam int BIT_RW = 1;
    localparam int BIT_US = 2;
    localparam int BIT_PS = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_CLEAR,
        S_LINK,
        S_DREAD,
        S_DWAIT,
        S_DDEC,
        S_SCAN,
        S_SCANCHK,
        S_TCLEAR,
        S_WTAB,
        S_OUT
    } t_state;

endpackage

/* src/tlpt_ram.sv */
module tlpt_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/two_level_page_table_manager.sv */
// Channel | Direction | Handshake         | Payload
// input   | in        | i_valid/o_stall   | req_type dir_slot virt_addr phys_addr user writable large
// output  | out       | o_valid/i_stall   | status slot flush flush_vpn
// config  | in        | i_cfg_we          | pool_frame
// Requests run one at a time; directories and tables sit in one word memory, the
// slot bitmap in registers. Create, and a map that needs a new table, search the
// bitmap and then zero the new structure. Free reads 1024 directory words and
// zeroes each released table and then the directory. An unmap whose directory
// entry points to a table also zeroes that table. Reset is synchronous; a stalled
// result holds.
`include "two_level_page_table_manager_assert.svh"

module two_level_page_table_manager
    import tlpt_pkg::*;
#(
    parameter int POOL_SLOTS = PoolSlotsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_dir_slot,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic        i_user,
    input  logic        i_writable,
    input  logic        i_large_req,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot,
    output logic        o_flush,
    output logic [19:0] o_flush_vpn
);

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int EW = $clog2(EntriesDef);
    localparam int AW = SW + EW;

    t_state r_state, n_state;
    logic [19:0] r_pool;
    logic [POOL_SLOTS-1:0] r_used;
    logic [1:0]  r_req;
    logic [SW-1:0] r_dslot;
    logic [31:0] r_va, r_pa;
    logic r_u, r_rw, r_lg;
    logic [SW-1:0] r_sptr;
    logic [EW-1:0] r_cnt;
    logic [EW-1:0] r_scan;
    logic [SW-1:0] r_cslot;
    logic [SW-1:0] r_tslot;
    logic [1:0] r_status;
    logic [5:0] r_oslot;
    logic r_flush;
    logic r_grab_dir;
    logic r_scanning;
    logic r_scan_last;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata, rdata;

    tlpt_ram #(.Width(32), .Depth(POOL_SLOTS * EntriesDef)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [EW-1:0] pdi, pti;
    logic [19:0] ent_slot;
    logic ent_in_pool;
    logic [31:0] flags;
    assign pdi = r_va[31:22];
    assign pti = r_va[21:12];
    assign ent_slot = rdata[31:12] - r_pool;
    assign ent_in_pool = ent_slot < 20'(POOL_SLOTS);
    assign flags = {29'd0, r_u, r_rw, 1'b1};

    logic dir_ok;
    assign dir_ok = 32'(i_dir_slot) < 32'(POOL_SLOTS);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_slot = r_oslot;
    assign o_flush = r_flush;
    assign o_flush_vpn = r_flush ? r_va[31:12] : 20'd0;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == REQ_CREATE) n_state = S_SEARCH;
                    else if (!dir_ok) n_state = S_OUT;
                    else if (i_req_type == REQ_FREE) n_state = S_SCAN;
                    else n_state = S_DREAD;
                end
            end
            S_SEARCH: begin
                if (!r_used[r_sptr]) n_state = S_CLEAR;
                else if (32'(r_sptr) == 32'(POOL_SLOTS - 1)) n_state = S_OUT;
            end
            S_CLEAR: if (r_cnt == EW'(EntriesDef - 1)) n_state = r_grab_dir ? S_OUT : S_LINK;
            S_LINK: n_state = S_WTAB;
            S_DREAD: n_state = S_DWAIT;
            S_DWAIT: n_state = S_DDEC;
            S_DDEC: begin
                if (r_req == REQ_MAP) begin
                    if (r_lg) n_state = S_OUT;
                    else if (rdata[BIT_P] && rdata[BIT_PS]) n_state = S_OUT;
                    else if (rdata[BIT_P]) n_state = ent_in_pool ? S_WTAB : S_OUT;
                    else n_state = S_SEARCH;
                end else begin
                    if (rdata[BIT_P] && !rdata[BIT_PS] && ent_in_pool) n_state = S_TCLEAR;
                    else n_state = S_OUT;
                end
            end
            S_SCAN: n_state = S_SCANCHK;
            S_SCANCHK: begin
                if (rdata[BIT_P] && !rdata[BIT_PS] && ent_in_pool) n_state = S_TCLEAR;
                else if (r_scan_last) n_state = S_TCLEAR;
                else n_state = S_SCAN;
            end
            S_TCLEAR: begin
                if (r_cnt == EW'(EntriesDef - 1)) begin
                    if (r_req == REQ_FREE && r_scanning) n_state = r_scan_last ? S_TCLEAR : S_SCAN;
                    else n_state = S_OUT;
                end
            end
            S_WTAB: n_state = S_OUT;
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = {r_dslot, pdi};
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                waddr = {r_sptr, r_cnt};
            end
            // The new table is linked only after it has been zeroed, since it may be
            // the directory slot itself.
            S_LINK: begin
                we = 1'b1;
                waddr = {r_dslot, pdi};
                wdata = {r_pool + 20'(r_tslot), 12'h007};
            end
            S_TCLEAR: begin
                we = 1'b1;
                waddr = {r_cslot, r_cnt};
            end
            S_SCAN: raddr = {r_dslot, r_scan};
            S_DDEC: begin
                if (r_req == REQ_MAP && r_lg) begin
                    we = 1'b1;
                    waddr = {r_dslot, pdi};
                    wdata = {r_pa[31:22], 22'd0} | 32'h80 | flags;
                end else if (r_req == REQ_UNMAP && rdata[BIT_P]) begin
                    we = 1'b1;
                    waddr = {r_dslot, pdi};
                end
            end
            S_WTAB: begin
                we = 1'b1;
                waddr = {r_tslot, pti};
                wdata = {r_pa[31:12], 12'd0} | flags;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pool <= '0;
            r_used <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_pool <= i_cfg_wdata;
            if (r_state == S_SEARCH && !r_used[r_sptr]) r_used[r_sptr] <= 1'b1;
            if (r_state == S_TCLEAR && r_cnt == EW'(EntriesDef - 1)) r_used[r_cslot] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_req <= i_req_type;
                r_dslot <= SW'(i_dir_slot);
                r_va <= i_virt_addr;
                r_pa <= i_phys_addr;
                r_u <= i_user;
                r_rw <= i_writable;
                r_lg <= i_large_req;
                r_sptr <= '0;
                r_cnt <= '0;
                r_scan <= '0;
                r_status <= ST_OK;
                r_oslot <= '0;
                r_flush <= 1'b0;
                r_grab_dir <= (i_req_type == REQ_CREATE);
                r_scanning <= 1'b1;
                r_scan_last <= 1'b0;
            end
            S_SEARCH: begin
                r_cnt <= '0;
                if (!r_used[r_sptr]) begin
                    r_tslot <= r_sptr;
                    if (r_grab_dir) r_oslot <= 6'(r_sptr);
                end else if (32'(r_sptr) == 32'(POOL_SLOTS - 1)) begin
                    r_status <= ST_NOMEM;
                end else begin
                    r_sptr <= r_sptr + 1'b1;
                end
            end
            S_CLEAR: r_cnt <= r_cnt + 1'b1;
            S_DDEC: begin
                r_cnt <= '0;
                if (r_req == REQ_MAP) begin
                    if (!r_lg && rdata[BIT_P] && rdata[BIT_PS]) r_status <= ST_CONFLICT;
                    r_tslot <= ent_slot[SW-1:0];
                end else begin
                    r_cslot <= ent_slot[SW-1:0];
                    r_scanning <= 1'b0;
                    if (rdata[BIT_P]) r_flush <= 1'b1;
                end
            end
            S_SCAN: begin
                r_scan_last <= (r_scan == EW'(EntriesDef - 1));
                r_scan <= r_scan + 1'b1;
            end
            S_SCANCHK: begin
                r_cnt <= '0;
                if (rdata[BIT_P] && !rdata[BIT_PS] && ent_in_pool) begin
                    r_cslot <= ent_slot[SW-1:0];
                end else if (r_scan_last) begin
                    r_cslot <= r_dslot;
                    r_scanning <= 1'b0;
                end
            end
            S_TCLEAR: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == EW'(EntriesDef - 1)) begin
                    // After the last table of the scan, the directory itself goes.
                    if (r_scanning && r_scan_last) begin
                        r_cslot <= r_dslot;
                        r_scanning <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    `TLPT_ASSERT(a_out_status, i_clk, i_rst_n,
        !o_valid || o_status != 2'd3, "status code out of range")
    `TLPT_ASSERT(a_flush_unmap, i_clk, i_rst_n,
        !(o_valid && o_flush) || r_req == REQ_UNMAP, "flush on non-unmap")
    `TLPT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n,
        i_valid && !o_stall, o_stall, "block not busy after accept")

endmodule
